FILE: hw/rtl/hcg_pkg.sv
// hsl color gradient: shared fixed-point constants, types and codes
// no dependencies
`default_nettype none

package hcg_pkg;

  localparam int HSL_FRAC_BITS = 16;
  localparam int FX_W          = HSL_FRAC_BITS + 1;

  typedef logic [FX_W-1:0] fx_t;

  localparam fx_t FX_ONE        = fx_t'(1) << HSL_FRAC_BITS;
  localparam fx_t FX_HALF       = fx_t'(1) << (HSL_FRAC_BITS - 1);
  localparam fx_t FX_THIRD      = fx_t'((2 ** HSL_FRAC_BITS + 1) / 3);
  localparam fx_t FX_TWO_THIRDS = fx_t'((2 * 2 ** HSL_FRAC_BITS + 1) / 3);

  typedef struct packed {
    fx_t h;
    fx_t s;
    fx_t l;
  } hsl_t;

  typedef enum logic [1:0] {
    REG_RANGE_LOW,
    REG_RANGE_HIGH,
    REG_COLOR_LOW,
    REG_COLOR_HIGH
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MAP_LOW,
    MAP_HIGH,
    MAP_LERP
  } map_mode_t;

  typedef enum logic [1:0] {
    EP_IDLE,
    EP_LAUNCH,
    EP_WAIT
  } ep_state_t;

  typedef enum logic [1:0] {
    EK_SAT,
    EK_HUE
  } ep_kind_t;

  typedef enum logic [1:0] {
    PC_RISE,
    PC_TOP,
    PC_FALL,
    PC_BASE
  } piece_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hcg_seq_div.sv
// hsl color gradient: bit-serial restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module hcg_seq_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, num_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r <= num_r << 1;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

FILE: hw/rtl/hcg_endpoint.sv
// hsl color gradient: converts both endpoint colors to hsl after reset or a write
// depends on hcg_pkg and hcg_seq_div
`default_nettype none

module hcg_endpoint
  import hcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        restart,
  input  logic [23:0] color_low,
  input  logic [23:0] color_high,
  output hsl_t        ep_low,
  output hsl_t        ep_high,
  output logic        busy
);

  localparam int NUM_W = 27;
  localparam int DEN_W = 11;
  // floor(sum * one / 510) as sum * ceil(2^32 / 255) >> 17, exact for sum up to 510
  localparam logic [24:0] L_RECIP = 25'd16843010;
  localparam int          L_SHIFT = 33 - HSL_FRAC_BITS;

  ep_state_t  state_r, state_nxt;
  ep_kind_t   kind_r, kind_nxt;
  logic       sel_r, sel_nxt;
  logic       pending_r, pending_nxt;
  hsl_t       ep_low_r, ep_high_r;

  logic [23:0]      col;
  logic [7:0]       r, g, b, mx, mn, d;
  logic [8:0]       sum;
  logic [9:0]       den_sat;
  logic [DEN_W-1:0] d2, d4, d6, n;
  logic             gray;
  logic [33:0]      l_prod;
  fx_t              lgt;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quo;
  logic             div_start, div_done, step_done, last;
  fx_t              res;

  always_comb begin
    col  = sel_r ? color_high : color_low;
    r    = col[23:16];
    g    = col[15:8];
    b    = col[7:0];
    mx   = r;
    mn   = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum  = {1'b0, mx} + {1'b0, mn};
    d    = mx - mn;
    gray = (mx == mn);
    den_sat = (sum > 9'd255) ? (10'd510 - {1'b0, sum}) : {1'b0, sum};
    d2   = DEN_W'({d, 1'b0});
    d4   = DEN_W'({d, 2'b00});
    d6   = d2 + d4;
    if (r > g && r > b) begin
      n = (g >= b) ? DEN_W'(g - b) : d6 - DEN_W'(b - g);
    end else if (g > b) begin
      n = d2 + DEN_W'(b) - DEN_W'(r);
    end else begin
      n = d4 + DEN_W'(r) - DEN_W'(g);
    end
    l_prod = 34'(sum) * 34'(L_RECIP);
    lgt    = l_prod[L_SHIFT+FX_W-1:L_SHIFT];
  end

  always_comb begin
    case (kind_r)
      EK_SAT: begin
        div_num = NUM_W'(d) << HSL_FRAC_BITS;
        div_den = DEN_W'(den_sat);
      end
      EK_HUE: begin
        div_num = NUM_W'(n) << HSL_FRAC_BITS;
        div_den = d6;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  hcg_seq_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign last = sel_r && (kind_r == EK_HUE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      EP_IDLE:   if (pending_r) state_nxt = EP_LAUNCH;
      EP_LAUNCH: state_nxt = EP_WAIT;
      EP_WAIT:   if (div_done) state_nxt = last ? EP_IDLE : EP_LAUNCH;
      default:   state_nxt = EP_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    div_start = (state_r == EP_LAUNCH);
    step_done = (state_r == EP_WAIT) && div_done;
    busy      = pending_r || (state_r != EP_IDLE);
  end

  always_comb begin
    sel_nxt     = sel_r;
    kind_nxt    = kind_r;
    pending_nxt = restart || (pending_r && (state_r != EP_IDLE));
    if (state_r == EP_IDLE) begin
      sel_nxt  = 1'b0;
      kind_nxt = EK_SAT;
    end else if (step_done) begin
      case (kind_r)
        EK_SAT: kind_nxt = EK_HUE;
        default: begin
          kind_nxt = EK_SAT;
          sel_nxt  = 1'b1;
        end
      endcase
    end
  end

  assign res = gray ? '0 : div_quo[FX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= EP_IDLE;
      kind_r    <= EK_SAT;
      sel_r     <= 1'b0;
      pending_r <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      kind_r    <= kind_nxt;
      sel_r     <= sel_nxt;
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_done) begin
      case (kind_r)
        EK_SAT: begin
          if (sel_r) begin
            ep_high_r.s <= res;
            ep_high_r.l <= lgt;
          end else begin
            ep_low_r.s <= res;
            ep_low_r.l <= lgt;
          end
        end
        default:  if (sel_r) ep_high_r.h <= res; else ep_low_r.h <= res;
      endcase
    end
  end

  assign ep_low  = ep_low_r;
  assign ep_high = ep_high_r;

endmodule

`default_nettype wire

FILE: hw/rtl/hcg_map.sv
// hsl color gradient: range check and pipelined linear map of h, s and l
// depends on hcg_pkg
`default_nettype none

module hcg_map
  import hcg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [15:0] level,
  input  logic signed [15:0] range_low,
  input  logic signed [15:0] range_high,
  input  hsl_t               ep_low,
  input  hsl_t               ep_high,
  output hsl_t               hsl,
  output logic               hsl_vld
);

  localparam int DIV_STAGES = FX_W;
  localparam int N_W        = 32;

  fx_t              ol [0:2];
  fx_t              oh [0:2];
  logic             neg [0:2];
  fx_t              mag [0:2];
  logic signed [FX_W:0] df;

  map_mode_t        s1_mode_r, s1_mode;
  logic [15:0]      s1_dx_r, s1_dd_r;
  logic             s1_vld_r;

  logic [15:0]           rem_s [0:DIV_STAGES][0:2];
  fx_t                   q_s   [0:DIV_STAGES][0:2];
  logic [DIV_STAGES-1:0] nl_s  [0:DIV_STAGES][0:2];
  logic [15:0]           dd_s  [0:DIV_STAGES];
  map_mode_t             mode_s [0:DIV_STAGES];
  logic                  vld_s [0:DIV_STAGES];

  logic [15:0] rem_nxt [1:DIV_STAGES][0:2];
  fx_t         q_nxt   [1:DIV_STAGES][0:2];
  logic [N_W-1:0] prod [0:2];
  fx_t         res [0:2];
  hsl_t        hsl_r;
  logic        hsl_vld_r;

  always_comb begin
    ol[0] = ep_low.h;
    ol[1] = ep_low.s;
    ol[2] = ep_low.l;
    oh[0] = ep_high.h;
    oh[1] = ep_high.s;
    oh[2] = ep_high.l;
    df    = '0;
    for (int c = 0; c < 3; c++) begin
      df     = {1'b0, oh[c]} - {1'b0, ol[c]};
      neg[c] = df[FX_W];
      mag[c] = neg[c] ? fx_t'(-df) : fx_t'(df);
    end
  end

  always_comb begin
    if (level < range_low) begin
      s1_mode = MAP_LOW;
    end else if (level > range_high) begin
      s1_mode = MAP_HIGH;
    end else if (range_low == range_high) begin
      s1_mode = MAP_LOW;
    end else begin
      s1_mode = MAP_LERP;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = {16'b0, s1_dx_r} * {{(N_W - FX_W){1'b0}}, mag[c]};
    end
  end

  // one quotient bit per stage
  always_comb begin
    logic [16:0] trial;
    logic [16:0] sub;
    trial = '0;
    sub   = '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      for (int c = 0; c < 3; c++) begin
        trial = {rem_s[k][c], nl_s[k][c][DIV_STAGES-1-k]};
        sub   = trial - {1'b0, dd_s[k]};
        q_nxt[k+1][c] = q_s[k][c];
        if (trial >= {1'b0, dd_s[k]}) begin
          rem_nxt[k+1][c] = sub[15:0];
          q_nxt[k+1][c][DIV_STAGES-1-k] = 1'b1;
        end else begin
          rem_nxt[k+1][c] = trial[15:0];
        end
      end
    end
  end

  always_comb begin
    logic [FX_W:0] v;
    v = '0;
    for (int c = 0; c < 3; c++) begin
      if (neg[c]) begin
        v = {1'b0, ol[c]} - {1'b0, q_s[DIV_STAGES][c]}
            - {{FX_W{1'b0}}, (rem_s[DIV_STAGES][c] != '0)};
      end else begin
        v = {1'b0, ol[c]} + {1'b0, q_s[DIV_STAGES][c]};
      end
      case (mode_s[DIV_STAGES])
        MAP_HIGH: res[c] = oh[c];
        MAP_LERP: res[c] = v[FX_W-1:0];
        default:  res[c] = ol[c];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      hsl_vld_r <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        vld_s[k] <= 1'b0;
      end
    end else if (en) begin
      s1_vld_r  <= in_vld;
      vld_s[0]  <= s1_vld_r;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        vld_s[k] <= vld_s[k-1];
      end
      hsl_vld_r <= vld_s[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode_r <= s1_mode;
      s1_dx_r   <= 16'(level - range_low);
      s1_dd_r   <= 16'(range_high - range_low);
      dd_s[0]   <= s1_dd_r;
      mode_s[0] <= s1_mode_r;
      for (int c = 0; c < 3; c++) begin
        rem_s[0][c] <= 16'(prod[c][N_W-1:DIV_STAGES]);
        nl_s[0][c]  <= prod[c][DIV_STAGES-1:0];
        q_s[0][c]   <= '0;
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
        dd_s[k]   <= dd_s[k-1];
        mode_s[k] <= mode_s[k-1];
        for (int c = 0; c < 3; c++) begin
          rem_s[k][c] <= rem_nxt[k][c];
          q_s[k][c]   <= q_nxt[k][c];
          nl_s[k][c]  <= nl_s[k-1][c];
        end
      end
      hsl_r.h <= res[0];
      hsl_r.s <= res[1];
      hsl_r.l <= res[2];
    end
  end

  assign hsl     = hsl_r;
  assign hsl_vld = hsl_vld_r;

endmodule

`default_nettype wire

FILE: hw/rtl/hcg_rgb.sv
// hsl color gradient: four-stage hsl to rgb conversion with output register
// depends on hcg_pkg
`default_nettype none

module hcg_rgb
  import hcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        hsl_vld,
  input  hsl_t        hsl,
  output logic [23:0] color,
  output logic        color_vld
);

  // stage 1: q and p
  logic [2*FX_W-1:0]  ls_full;
  fx_t                ls;
  logic signed [18:0] q1, p1;
  logic signed [18:0] r1_q_r, r1_p_r;
  fx_t                r1_h_r, r1_l_r;
  logic               r1_sz_r, r1_vld_r;

  // stage 2: piece select and slope factor
  logic signed [18:0] th, t;
  fx_t                tu, tt;
  logic [19:0]        t6;
  piece_t             pc2 [0:2];
  fx_t                f2  [0:2];
  piece_t             r2_pc_r [0:2];
  fx_t                r2_f_r  [0:2];
  logic [17:0]        r2_qp_r;
  logic signed [18:0] r2_q_r, r2_p_r;
  fx_t                r2_l_r;
  logic               r2_sz_r, r2_vld_r;

  // stage 3: slope product
  logic [34:0]        prod [0:2];
  logic [18:0]        r3_ph_r [0:2];
  piece_t             r3_pc_r [0:2];
  logic signed [18:0] r3_q_r, r3_p_r;
  fx_t                r3_l_r;
  logic               r3_sz_r, r3_vld_r;

  // stage 4: clamp and scale to 8 bits
  logic signed [19:0] v;
  fx_t                vc;
  logic [24:0]        scaled;
  logic [7:0]         ch [0:2];
  logic [23:0]        color_r;
  logic               color_vld_r;

  always_comb begin
    ls_full = {{FX_W{1'b0}}, hsl.l} * {{FX_W{1'b0}}, hsl.s};
    ls      = ls_full[HSL_FRAC_BITS+FX_W-1:HSL_FRAC_BITS];
    if (hsl.l < FX_HALF) begin
      q1 = 19'(hsl.l) + 19'(ls);
    end else begin
      q1 = 19'(hsl.l) + 19'(hsl.s) - 19'(ls);
    end
    p1 = 19'({hsl.l, 1'b0}) - q1;
  end

  always_comb begin
    th = 19'(r1_h_r);
    t  = '0;
    tu = '0;
    tt = '0;
    t6 = '0;
    for (int c = 0; c < 3; c++) begin
      case (c)
        0:       t = th + 19'(FX_THIRD);
        1:       t = th;
        default: t = th - 19'(FX_THIRD);
      endcase
      if (t < 0) begin
        t = t + 19'(FX_ONE);
      end else if (t > 19'(FX_ONE)) begin
        t = t - 19'(FX_ONE);
      end
      tu = t[FX_W-1:0];
      t6 = 20'({tu, 2'b00}) + 20'({tu, 1'b0});
      tt = FX_TWO_THIRDS - tu;
      f2[c] = '0;
      if (t6 < 20'(FX_ONE)) begin
        pc2[c] = PC_RISE;
        f2[c]  = t6[FX_W-1:0];
      end else if ({tu, 1'b0} < {1'b0, FX_ONE}) begin
        pc2[c] = PC_TOP;
      end else if (20'({tu, 1'b0}) + 20'(tu) < 20'({FX_ONE, 1'b0})) begin
        pc2[c] = PC_FALL;
        f2[c]  = fx_t'({tt, 2'b00}) + fx_t'({tt, 1'b0});
      end else begin
        pc2[c] = PC_BASE;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = {17'b0, r2_qp_r} * {18'b0, r2_f_r[c]};
    end
  end

  always_comb begin
    v      = '0;
    vc     = '0;
    scaled = '0;
    for (int c = 0; c < 3; c++) begin
      case (r3_pc_r[c]) inside
        PC_RISE, PC_FALL: v = 20'(r3_p_r) + $signed({1'b0, r3_ph_r[c]});
        PC_TOP:           v = 20'(r3_q_r);
        default:          v = 20'(r3_p_r);
      endcase
      if (r3_sz_r) begin
        vc = r3_l_r;
      end else if (v < 0) begin
        vc = '0;
      end else if (v > 20'(FX_ONE)) begin
        vc = FX_ONE;
      end else begin
        vc = v[FX_W-1:0];
      end
      scaled = {vc, 8'b0} - {8'b0, vc};
      ch[c]  = scaled[HSL_FRAC_BITS+7:HSL_FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r    <= 1'b0;
      r2_vld_r    <= 1'b0;
      r3_vld_r    <= 1'b0;
      color_vld_r <= 1'b0;
    end else if (en) begin
      r1_vld_r    <= hsl_vld;
      r2_vld_r    <= r1_vld_r;
      r3_vld_r    <= r2_vld_r;
      color_vld_r <= r3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_q_r  <= q1;
      r1_p_r  <= p1;
      r1_h_r  <= hsl.h;
      r1_l_r  <= hsl.l;
      r1_sz_r <= (hsl.s == '0);

      r2_qp_r <= 18'(r1_q_r - r1_p_r);
      r2_q_r  <= r1_q_r;
      r2_p_r  <= r1_p_r;
      r2_l_r  <= r1_l_r;
      r2_sz_r <= r1_sz_r;
      for (int c = 0; c < 3; c++) begin
        r2_pc_r[c] <= pc2[c];
        r2_f_r[c]  <= f2[c];
      end

      r3_q_r  <= r2_q_r;
      r3_p_r  <= r2_p_r;
      r3_l_r  <= r2_l_r;
      r3_sz_r <= r2_sz_r;
      for (int c = 0; c < 3; c++) begin
        r3_pc_r[c] <= r2_pc_r[c];
        r3_ph_r[c] <= prod[c][34:HSL_FRAC_BITS];
      end

      color_r <= {ch[0], ch[1], ch[2]};
    end
  end

  assign color     = color_r;
  assign color_vld = color_vld_r;

endmodule

`default_nettype wire

FILE: hw/rtl/hsl_color_gradient.sv
// hsl color gradient top level: config registers, endpoint converter, map and rgb pipes
// depends on hcg_pkg, hcg_endpoint, hcg_map and hcg_rgb
//
// usage
//   in_level (signed q8.8) enters on the in_ channel, one word per cycle while
//   in_ready is high. out_color returns the interpolated 24-bit rgb color on
//   the out_ channel. throughput is one word per cycle while the output is not
//   stalled, set by the 24-stage pipe (17 of them one quotient bit each).
//   cfg_we writes register cfg_index with cfg_data: 0 range_low, 1 range_high,
//   2 color_low, 3 color_high. every write, and reset, starts the endpoint
//   converter, which turns both colors into hsl with one bit-serial divider
//   for saturation and hue (lightness by reciprocal multiplication), four divisions
//   in all. in_ready stays low while it runs and in the cycle of a write.
//   after reset registers hold their reset values and the pipe is empty.
//   when out_ready is low with a word waiting, the whole pipe holds; nothing
//   is dropped or repeated, and in_ready follows.
`default_nettype none

module hsl_color_gradient
  import hcg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_color,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  logic signed [15:0] range_low_r, range_high_r;
  logic [23:0]        color_low_r, color_high_r;
  hsl_t               ep_low, ep_high, map_hsl;
  logic               ep_busy, en, accept, map_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= 16'sd0;
      range_high_r <= 16'sd25600;
      color_low_r  <= 24'h00ff00;
      color_high_r <= 24'hff0000;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RANGE_LOW:  range_low_r  <= cfg_data[15:0];
        REG_RANGE_HIGH: range_high_r <= cfg_data[15:0];
        REG_COLOR_LOW:  color_low_r  <= cfg_data;
        REG_COLOR_HIGH: color_high_r <= cfg_data;
        default:        color_high_r <= color_high_r;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en && !ep_busy && !cfg_we;
  assign accept   = in_valid && in_ready;

  hcg_endpoint u_endpoint (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_we),
    .color_low  (color_low_r),
    .color_high (color_high_r),
    .ep_low     (ep_low),
    .ep_high    (ep_high),
    .busy       (ep_busy)
  );

  hcg_map u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (accept),
    .level      (in_level),
    .range_low  (range_low_r),
    .range_high (range_high_r),
    .ep_low     (ep_low),
    .ep_high    (ep_high),
    .hsl        (map_hsl),
    .hsl_vld    (map_vld)
  );

  hcg_rgb u_rgb (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .hsl_vld   (map_vld),
    .hsl       (map_hsl),
    .color     (out_color),
    .color_vld (out_valid)
  );

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ep_busy |-> !in_ready)
    else $error("input accepted while endpoint conversion runs");

  a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> ep_busy)
    else $error("register write did not restart endpoint conversion");

  a_reset_converts: assert property (@(posedge clk)
    !rst_n |=> ep_busy)
    else $error("endpoint conversion not pending after reset");

endmodule

`default_nettype wire
